// ----- src/rwmc_pkg.sv -----
// ----------------------------------------------------------------------------
// rwmc_pkg
// shared constants, cell encoding and helpers for the random walk maze carver
// ----------------------------------------------------------------------------
package rwmc_pkg;

  // largest grid side in use
  localparam int MAX_DIM  = 64;
  // width of a coordinate field and of a grid size register
  localparam int COORD_W  = 6;
  localparam int DIM_W    = 7;
  localparam int PROD_W   = 2 * DIM_W;
  localparam int CNT_W    = 13;
  // cell store: address is {row, col}
  localparam int CELL_AW  = 2 * COORD_W;
  localparam int CELLS    = 1 << CELL_AW;
  localparam int CELL_W   = 3;

  // cell bits
  localparam logic [CELL_W-1:0] CELL_RIGHT   = 3'b001;
  localparam logic [CELL_W-1:0] CELL_BOTTOM  = 3'b010;
  localparam logic [CELL_W-1:0] CELL_VISITED = 3'b100;
  localparam logic [CELL_W-1:0] CELL_FRESH   = CELL_RIGHT | CELL_BOTTOM;

  // commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // step directions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // configuration register indexes
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

endpackage

// ----- src/rwmc_ram.sv -----
// ----------------------------------------------------------------------------
// rwmc_ram
// generic single-port ram with registered read data
// ----------------------------------------------------------------------------
module rwmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/random_walk_maze_carver.sv -----
// ----------------------------------------------------------------------------
// random_walk_maze_carver
// aldous-broder maze carver over a cell store in one single-port ram
// ----------------------------------------------------------------------------
// Each item returns exactly one result. The cell store is a single-port ram of
// 4096 entries with a registered read, and its one port sets the timing: a
// step reads the target, then writes it if it was unvisited, and when it
// carves downward or rightward the walker's own cell is written after that; a
// read reads its cell once; a step that goes nowhere and the unused command go
// straight to the result. A good start command sweeps the whole store, one
// entry a cycle. After reset the same clearing pass runs with the input
// stalled; configuration writes are taken at any time. A finished result waits
// in the output register while the next item is already taken.
// ----------------------------------------------------------------------------
module random_walk_maze_carver
  import rwmc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [DIM_W-1:0]   cfg_data_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [1:0]         direction_i,
  input  logic [COORD_W-1:0] cell_x_i,
  input  logic [COORD_W-1:0] cell_y_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COORD_W-1:0] walker_x_o,
  output logic [COORD_W-1:0] walker_y_o,
  output logic               carved_o,
  output logic [CNT_W-1:0]   cells_left_o,
  output logic               finished_o,
  output logic [1:0]         cell_code_o,
  output logic               bad_coordinate_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_HERE  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [CELL_AW-1:0] clr_ctr_q;
  logic               mark_en_q;
  logic [CELL_AW-1:0] start_addr_q;
  logic [DIM_W-1:0]   grid_rows_q, grid_cols_q;
  logic [COORD_W-1:0] walker_x_q, walker_y_q;
  logic [CNT_W-1:0]   count_q;
  logic [CELL_W-1:0]  here_q, nxt_cell_q;
  logic [COORD_W-1:0] tgt_x_q, tgt_y_q;
  logic [1:0]         dir_q;
  logic               carved_q, bad_q;
  logic [1:0]         code_q;

  logic               out_valid_q;
  logic [COORD_W-1:0] out_x_q, out_y_q;
  logic               out_carved_q, out_finished_q, out_bad_q;
  logic [CNT_W-1:0]   out_count_q;
  logic [1:0]         out_code_q;

  logic               out_free, out_load, take;
  logic [DIM_W-1:0]   rows, cols;
  logic               coord_bad, axis_ok, step_ok;
  logic [DIM_W-1:0]   tc7, tr7;
  logic [PROD_W-1:0]  area;
  logic [CELL_W-1:0]  ram_rdata, ram_wdata, there_new, here_wall;
  logic [CELL_AW-1:0] ram_addr;
  logic               ram_we;
  logic               carve_here;

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_DONE) && out_free;
  assign in_stall_o = !((state_q == ST_IDLE) || out_load);
  assign take = in_valid_i && !in_stall_o;

  assign rows = clamp_dim(grid_rows_q);
  assign cols = clamp_dim(grid_cols_q);
  assign coord_bad = ({1'b0, cell_x_i} >= cols) || ({1'b0, cell_y_i} >= rows);
  assign area = {{DIM_W{1'b0}}, rows} * {{DIM_W{1'b0}}, cols};

  // target of a step from the current walker position
  always_comb begin
    tc7 = {1'b0, walker_x_q};
    tr7 = {1'b0, walker_y_q};
    axis_ok = 1'b0;
    unique case (direction_i)
      DIR_UP: begin
        axis_ok = (walker_y_q != '0) && ((tr7 - DIM_W'(1)) < rows);
        tr7 = tr7 - DIM_W'(1);
      end
      DIR_DOWN: begin
        axis_ok = (tr7 + DIM_W'(1)) < rows;
        tr7 = tr7 + DIM_W'(1);
      end
      DIR_LEFT: begin
        axis_ok = (walker_x_q != '0) && ((tc7 - DIM_W'(1)) < cols);
        tc7 = tc7 - DIM_W'(1);
      end
      default: begin
        axis_ok = (tc7 + DIM_W'(1)) < cols;
        tc7 = tc7 + DIM_W'(1);
      end
    endcase
    step_ok = axis_ok && (tc7 < cols) && (tr7 < rows);
  end

  // wall changes of a carving step
  always_comb begin
    there_new = ram_rdata | CELL_VISITED;
    here_wall = CELL_RIGHT;
    unique case (dir_q)
      DIR_UP:   there_new = there_new & ~CELL_BOTTOM;
      DIR_LEFT: there_new = there_new & ~CELL_RIGHT;
      DIR_DOWN: here_wall = CELL_BOTTOM;
      default:  here_wall = CELL_RIGHT;
    endcase
  end

  assign carve_here = (dir_q == DIR_DOWN) || (dir_q == DIR_RIGHT);

  // memory port
  always_comb begin
    ram_we = 1'b0;
    ram_wdata = CELL_FRESH;
    if (cmd_i == CMD_READ) begin
      ram_addr = {cell_y_i, cell_x_i};
    end else begin
      ram_addr = {tr7[COORD_W-1:0], tc7[COORD_W-1:0]};
    end
    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_ctr_q;
        if (mark_en_q && (clr_ctr_q == start_addr_q)) begin
          ram_wdata = CELL_FRESH | CELL_VISITED;
        end
      end
      ST_STEP: begin
        ram_we = !ram_rdata[2];
        ram_addr = {tgt_y_q, tgt_x_q};
        ram_wdata = there_new;
      end
      ST_HERE: begin
        ram_we = 1'b1;
        ram_addr = {walker_y_q, walker_x_q};
        ram_wdata = here_q & ~here_wall;
      end
      default: ;
    endcase
  end

  rwmc_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_cell_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_ctr_q == '1) begin
          state_d = mark_en_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_READ: state_d = ST_DONE;
      ST_STEP: begin
        if (!ram_rdata[2] && carve_here) begin
          state_d = ST_HERE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_HERE: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (take) begin
      unique case (cmd_i)
        CMD_START: state_d = coord_bad ? ST_DONE : ST_CLEAR;
        CMD_STEP:  state_d = (count_q != '0 && step_ok) ? ST_STEP : ST_DONE;
        CMD_READ:  state_d = coord_bad ? ST_DONE : ST_READ;
        default:   state_d = ST_DONE;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_ctr_q   <= '0;
      mark_en_q   <= 1'b0;
      grid_rows_q <= DIM_W'(50);
      grid_cols_q <= DIM_W'(50);
      walker_x_q  <= '0;
      walker_y_q  <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_GRID_ROWS: grid_rows_q <= cfg_data_i;
          default:       grid_cols_q <= cfg_data_i;
        endcase
      end
      if (state_q == ST_CLEAR) begin
        clr_ctr_q <= clr_ctr_q + CELL_AW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (take && (cmd_i == CMD_START) && !coord_bad) begin
        clr_ctr_q  <= '0;
        mark_en_q  <= 1'b1;
        walker_x_q <= cell_x_i;
        walker_y_q <= cell_y_i;
        count_q    <= CNT_W'(area - PROD_W'(1));
      end
      if ((state_q == ST_STEP) && !ram_rdata[2]) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (((state_q == ST_STEP) && !(!ram_rdata[2] && carve_here)) ||
          (state_q == ST_HERE)) begin
        walker_x_q <= tgt_x_q;
        walker_y_q <= tgt_y_q;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      carved_q     <= 1'b0;
      code_q       <= 2'd0;
      bad_q        <= ((cmd_i == CMD_START) || (cmd_i == CMD_READ)) && coord_bad;
      dir_q        <= direction_i;
      tgt_x_q      <= tc7[COORD_W-1:0];
      tgt_y_q      <= tr7[COORD_W-1:0];
      start_addr_q <= {cell_y_i, cell_x_i};
      if ((cmd_i == CMD_START) && !coord_bad) begin
        here_q <= CELL_FRESH | CELL_VISITED;
      end
    end
    if (state_q == ST_READ) begin
      code_q <= ram_rdata[1:0];
    end
    if (state_q == ST_STEP) begin
      if (ram_rdata[2]) begin
        here_q <= ram_rdata;
      end else begin
        carved_q   <= 1'b1;
        nxt_cell_q <= there_new;
        if (!carve_here) begin
          here_q <= there_new;
        end
      end
    end
    if (state_q == ST_HERE) begin
      here_q <= nxt_cell_q;
    end
    if (out_load) begin
      out_x_q        <= walker_x_q;
      out_y_q        <= walker_y_q;
      out_carved_q   <= carved_q;
      out_count_q    <= count_q;
      out_finished_q <= (count_q == '0);
      out_code_q     <= code_q;
      out_bad_q      <= bad_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign walker_x_o       = out_x_q;
  assign walker_y_o       = out_y_q;
  assign carved_o         = out_carved_q;
  assign cells_left_o     = out_count_q;
  assign finished_o       = out_finished_q;
  assign cell_code_o      = out_code_q;
  assign bad_coordinate_o = out_bad_q;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the random walk maze carver: a directed table of
// corner cases, then maze walks on random grid sizes with random directions,
// reads and bad coordinates, each result checked against a walker/cell model
// ----------------------------------------------------------------------------
module testbench;
  import rwmc_pkg::*;

  localparam int TARGET_ITEMS = 1650;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int PLAN_LEN     = 31;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [1:0]         dir;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } walk_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] wx;
    logic [COORD_W-1:0] wy;
    logic               carved;
    logic [CNT_W-1:0]   left;
    logic               done;
    logic [1:0]         code;
    logic               bad;
  } walk_status_t;

  typedef struct packed {
    bit           is_cfg;
    logic [6:0]   rows_val;
    logic [6:0]   cols_val;
    walk_item_t   item;
    bit           typed;
    walk_status_t want;
  } plan_row_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_RUNS} rx_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_index_i = REG_GRID_ROWS;
  logic [DIM_W-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         cmd_i = CMD_NOP;
  logic [1:0]         direction_i = DIR_UP;
  logic [COORD_W-1:0] cell_x_i = '0;
  logic [COORD_W-1:0] cell_y_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [COORD_W-1:0] walker_x_o;
  logic [COORD_W-1:0] walker_y_o;
  logic               carved_o;
  logic [CNT_W-1:0]   cells_left_o;
  logic               finished_o;
  logic [1:0]         cell_code_o;
  logic               bad_coordinate_o;

  random_walk_maze_carver u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .direction_i     (direction_i),
    .cell_x_i        (cell_x_i),
    .cell_y_i        (cell_y_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .walker_x_o      (walker_x_o),
    .walker_y_o      (walker_y_o),
    .carved_o        (carved_o),
    .cells_left_o    (cells_left_o),
    .finished_o      (finished_o),
    .cell_code_o     (cell_code_o),
    .bad_coordinate_o(bad_coordinate_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model of the maze and the walker
  logic [CELL_W-1:0]  maze_cells [CELLS];
  logic [COORD_W-1:0] pos_col = '0;
  logic [COORD_W-1:0] pos_row = '0;
  int                 cells_unvisited = 0;
  logic [DIM_W-1:0]   rows_reg = 7'd50;
  logic [DIM_W-1:0]   cols_reg = 7'd50;

  walk_status_t pending_status [$];
  int error_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int n_items = 0, n_starts = 0, n_steps = 0, n_carved = 0, n_reads = 0;
  int n_mazes_done = 0, n_grid_sets = 0, n_bad = 0;

  rx_mode_e rx_mode = RX_FREE;
  int       rx_left = 0;

  initial begin
    foreach (maze_cells[i]) maze_cells[i] = CELL_FRESH;
  end

  // register value to the side length actually in use
  function automatic int span(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic walk_status_t next_walker_status(input walk_item_t it);
    walk_status_t r;
    int rows, cols, tc, tr, here, there;
    bit ok;
    rows = span(rows_reg);
    cols = span(cols_reg);
    r = '0;
    if (it.cmd == CMD_START || it.cmd == CMD_READ) begin
      if (it.x >= cols || it.y >= rows) begin
        r.bad = 1'b1;
      end else if (it.cmd == CMD_START) begin
        foreach (maze_cells[i]) maze_cells[i] = CELL_FRESH;
        pos_col = it.x;
        pos_row = it.y;
        maze_cells[{it.y, it.x}] = maze_cells[{it.y, it.x}] | CELL_VISITED;
        cells_unvisited = rows * cols - 1;
      end else begin
        r.code = maze_cells[{it.y, it.x}][1:0];
      end
    end else if (it.cmd == CMD_STEP && cells_unvisited != 0) begin
      tc = pos_col;
      tr = pos_row;
      ok = 1'b0;
      case (it.dir)
        DIR_UP: begin
          ok = tr >= 1 && tr - 1 < rows;
          if (ok) tr = tr - 1;
        end
        DIR_DOWN: begin
          ok = tr + 1 < rows;
          if (ok) tr = tr + 1;
        end
        DIR_LEFT: begin
          ok = tc >= 1 && tc - 1 < cols;
          if (ok) tc = tc - 1;
        end
        default: begin
          ok = tc + 1 < cols;
          if (ok) tc = tc + 1;
        end
      endcase
      // a walker stranded by a resize may still be off grid on the other axis
      if (ok && (tc >= cols || tr >= rows)) ok = 1'b0;
      if (ok) begin
        here = pos_row * MAX_DIM + pos_col;
        there = tr * MAX_DIM + tc;
        if ((maze_cells[there] & CELL_VISITED) == 0) begin
          case (it.dir)
            DIR_UP:   maze_cells[there] = maze_cells[there] & ~CELL_BOTTOM;
            DIR_DOWN: maze_cells[here] = maze_cells[here] & ~CELL_BOTTOM;
            DIR_LEFT: maze_cells[there] = maze_cells[there] & ~CELL_RIGHT;
            default:  maze_cells[here] = maze_cells[here] & ~CELL_RIGHT;
          endcase
          maze_cells[there] = maze_cells[there] | CELL_VISITED;
          cells_unvisited = cells_unvisited - 1;
          r.carved = 1'b1;
        end
        pos_col = tc[COORD_W-1:0];
        pos_row = tr[COORD_W-1:0];
      end
    end
    r.wx = pos_col;
    r.wy = pos_row;
    r.left = CNT_W'(cells_unvisited);
    r.done = (cells_unvisited == 0);
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return DIM_W'($urandom_range(65, 127));
    if (sel <= 3) return DIM_W'($urandom_range(9, 64));
    return DIM_W'($urandom_range(1, 7));
  endfunction

  // offer one item in bursts with random gaps, record its expected status
  task automatic push_item(input walk_item_t it, input bit typed, input walk_status_t want);
    walk_status_t predicted;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left = burst_left - 1;
    in_valid_i  <= 1'b1;
    cmd_i       <= it.cmd;
    direction_i <= it.dir;
    cell_x_i    <= it.x;
    cell_y_i    <= it.y;
    do @(posedge clk_i); while (in_stall_o);
    predicted = next_walker_status(it);
    pending_status = {pending_status, (typed ? want : predicted)};
    if (it.cmd != CMD_NOP) n_items = n_items + 1;
    if (predicted.bad) n_bad = n_bad + 1;
    else if (it.cmd == CMD_START) n_starts = n_starts + 1;
    if (it.cmd == CMD_READ) n_reads = n_reads + 1;
    if (it.cmd == CMD_STEP) n_steps = n_steps + 1;
    if (predicted.carved) begin
      n_carved = n_carved + 1;
      if (predicted.done) n_mazes_done = n_mazes_done + 1;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_status.size() != 0) @(posedge clk_i);
  endtask

  // both size registers, written only once the block has gone quiet
  task automatic set_grid(input logic [DIM_W-1:0] rows_val, input logic [DIM_W-1:0] cols_val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_GRID_ROWS;
    cfg_data_i  <= rows_val;
    @(posedge clk_i);
    cfg_index_i <= REG_GRID_COLS;
    cfg_data_i  <= cols_val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rows_reg = rows_val;
    cols_reg = cols_val;
    n_grid_sets = n_grid_sets + 1;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count = error_count + 1;
    end
  endtask

  always @(posedge clk_i) begin
    walk_status_t exp_s;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual x=%0d y=%0d left=%0d",
                 $time, walker_x_o, walker_y_o, cells_left_o);
        error_count = error_count + 1;
      end else begin
        exp_s = pending_status.pop_front();
        check_field("walker_x", exp_s.wx, walker_x_o);
        check_field("walker_y", exp_s.wy, walker_y_o);
        check_field("carved", exp_s.carved, carved_o);
        check_field("cells_left", exp_s.left, cells_left_o);
        check_field("finished", exp_s.done, finished_o);
        check_field("cell_code", exp_s.code, cell_code_o);
        check_field("bad_coordinate", exp_s.bad, bad_coordinate_o);
      end
    end
  end

  // result side stalls on a pattern, free, light, heavy or in runs, picked anew at random
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 300);
    end
    rx_left = rx_left - 1;
    case (rx_mode)
      RX_FREE:  out_stall_i <= 1'b0;
      RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:  out_stall_i <= (rx_left % 16) < 11;
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_status.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // directed corners: rows with a typed status are checked against it
  plan_row_t walk_plan [PLAN_LEN] = '{
    // idle after reset: finished, steps ignored, fresh walls, off-grid reads and starts, a good start
    '{1'b0, 7'd0, 7'd0, '{CMD_STEP, DIR_UP, 6'd0, 6'd0}, 1'b1,
      '{6'd0, 6'd0, 1'b0, 13'd0, 1'b1, 2'd0, 1'b0}},
    '{1'b0, 7'd0, 7'd0, '{CMD_READ, DIR_UP, 6'd0, 6'd0}, 1'b1,
      '{6'd0, 6'd0, 1'b0, 13'd0, 1'b1, 2'd3, 1'b0}},
    '{1'b0, 7'd0, 7'd0, '{CMD_NOP, DIR_RIGHT, 6'd63, 6'd63}, 1'b1,
      '{6'd0, 6'd0, 1'b0, 13'd0, 1'b1, 2'd0, 1'b0}},
    '{1'b0, 7'd0, 7'd0, '{CMD_READ, DIR_DOWN, 6'd63, 6'd63}, 1'b1,
      '{6'd0, 6'd0, 1'b0, 13'd0, 1'b1, 2'd0, 1'b1}},
    '{1'b0, 7'd0, 7'd0, '{CMD_START, DIR_UP, 6'd50, 6'd0}, 1'b1,
      '{6'd0, 6'd0, 1'b0, 13'd0, 1'b1, 2'd0, 1'b1}},
    '{1'b0, 7'd0, 7'd0, '{CMD_START, DIR_UP, 6'd0, 6'd50}, 1'b1,
      '{6'd0, 6'd0, 1'b0, 13'd0, 1'b1, 2'd0, 1'b1}},
    '{1'b0, 7'd0, 7'd0, '{CMD_START, DIR_UP, 6'd49, 6'd49}, 1'b1,
      '{6'd49, 6'd49, 1'b0, 13'd2499, 1'b0, 2'd0, 1'b0}},
    // corner of the default grid: off-grid steps, carving, revisit
    '{1'b0, 7'd0, 7'd0, '{CMD_STEP, DIR_DOWN, 6'd0, 6'd0}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{CMD_STEP, DIR_RIGHT, 6'd0, 6'd0}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{CMD_STEP, DIR_UP, 6'd0, 6'd0}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{CMD_STEP, DIR_LEFT, 6'd0, 6'd0}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{CMD_STEP, DIR_RIGHT, 6'd0, 6'd0}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{CMD_READ, DIR_UP, 6'd49, 6'd48}, 1'b0, '0},
    // one-cell grid, zero rows acting as one
    '{1'b1, 7'd0, 7'd1, '{CMD_NOP, DIR_UP, 6'd0, 6'd0}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{CMD_START, DIR_UP, 6'd0, 6'd0}, 1'b1,
      '{6'd0, 6'd0, 1'b0, 13'd0, 1'b1, 2'd0, 1'b0}},
    '{1'b0, 7'd0, 7'd0, '{CMD_STEP, DIR_RIGHT, 6'd0, 6'd0}, 1'b1,
      '{6'd0, 6'd0, 1'b0, 13'd0, 1'b1, 2'd0, 1'b0}},
    '{1'b0, 7'd0, 7'd0, '{CMD_READ, DIR_UP, 6'd1, 6'd0}, 1'b1,
      '{6'd0, 6'd0, 1'b0, 13'd0, 1'b1, 2'd0, 1'b1}},
    // full grid, rows register above the maximum
    '{1'b1, 7'd127, 7'd64, '{CMD_NOP, DIR_UP, 6'd0, 6'd0}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{CMD_START, DIR_UP, 6'd63, 6'd63}, 1'b1,
      '{6'd63, 6'd63, 1'b0, 13'd4095, 1'b0, 2'd0, 1'b0}},
    '{1'b0, 7'd0, 7'd0, '{CMD_STEP, DIR_UP, 6'd0, 6'd0}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{CMD_STEP, DIR_LEFT, 6'd0, 6'd0}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{CMD_READ, DIR_UP, 6'd63, 6'd62}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{CMD_READ, DIR_UP, 6'd0, 6'd0}, 1'b1,
      '{6'd62, 6'd62, 1'b0, 13'd4093, 1'b0, 2'd3, 1'b0}},
    // shrink under the walker: it is stranded outside the grid
    '{1'b1, 7'd2, 7'd2, '{CMD_NOP, DIR_UP, 6'd0, 6'd0}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{CMD_STEP, DIR_UP, 6'd0, 6'd0}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{CMD_STEP, DIR_LEFT, 6'd0, 6'd0}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{CMD_READ, DIR_UP, 6'd1, 6'd1}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{CMD_STEP, DIR_DOWN, 6'd0, 6'd0}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{CMD_STEP, DIR_RIGHT, 6'd0, 6'd0}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{CMD_READ, DIR_LEFT, 6'd0, 6'd1}, 1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{CMD_NOP, DIR_LEFT, 6'd1, 6'd1}, 1'b0, '0}
  };

  initial begin
    walk_item_t it;
    int walk_len, pick, eff_rows, eff_cols;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (walk_plan[i]) begin
      if (walk_plan[i].is_cfg) set_grid(walk_plan[i].rows_val, walk_plan[i].cols_val);
      else push_item(walk_plan[i].item, walk_plan[i].typed, walk_plan[i].want);
    end

    // random walks: a fresh grid size, a start, then mostly steps
    while (n_items < TARGET_ITEMS) begin
      set_grid(pick_dim(), pick_dim());
      eff_rows = span(rows_reg);
      eff_cols = span(cols_reg);
      it.cmd = CMD_START;
      it.dir = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) != 0) begin
        it.x = COORD_W'($urandom_range(0, eff_cols - 1));
        it.y = COORD_W'($urandom_range(0, eff_rows - 1));
      end else begin
        it.x = COORD_W'($urandom_range(0, 63));
        it.y = COORD_W'($urandom_range(0, 63));
      end
      push_item(it, 1'b0, '0);
      walk_len = $urandom_range(10, 90);
      repeat (walk_len) begin
        pick = $urandom_range(0, 99);
        it.dir = 2'($urandom_range(0, 3));
        it.x = COORD_W'($urandom_range(0, 63));
        it.y = COORD_W'($urandom_range(0, 63));
        if (pick < 78) begin
          it.cmd = CMD_STEP;
        end else if (pick < 86) begin
          it.cmd = CMD_READ;
          it.x = COORD_W'($urandom_range(0, eff_cols - 1));
          it.y = COORD_W'($urandom_range(0, eff_rows - 1));
        end else if (pick < 91) begin
          it.cmd = CMD_READ;
        end else if (pick < 95) begin
          it.cmd = CMD_NOP;
        end else if (pick < 98) begin
          // start outside the grid, rejected as a bad coordinate (a step on a full-size grid)
          it.cmd = CMD_STEP;
          if (eff_cols < MAX_DIM) begin
            it.cmd = CMD_START;
            it.x = COORD_W'($urandom_range(eff_cols, 63));
          end else if (eff_rows < MAX_DIM) begin
            it.cmd = CMD_START;
            it.y = COORD_W'($urandom_range(eff_rows, 63));
          end
        end else begin
          // resize in the middle of a walk
          set_grid(pick_dim(), pick_dim());
          eff_rows = span(rows_reg);
          eff_cols = span(cols_reg);
          it.cmd = CMD_STEP;
        end
        push_item(it, 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("covered %0d items: %0d walks started, %0d steps, %0d cells carved, %0d reads",
             n_items, n_starts, n_steps, n_carved, n_reads);
    $display("%0d mazes completed, %0d grid settings, %0d bad coordinates",
             n_mazes_done, n_grid_sets, n_bad);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/rwmc_pkg.sv
src/rwmc_ram.sv
src/random_walk_maze_carver.sv
tb/testbench.sv
